// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mucl_pkg.sv =====
`default_nettype none

package mucl_pkg;

    // Controller state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PICK   = 4'b0010,
        ST_ENTRY  = 4'b0100,
        ST_SIGNED = 4'b1000
    } t_state;

    // Mode codes as seen on the result
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_PICK   = 2'd1;
    localparam logic [1:0] MODE_ENTRY  = 2'd2;
    localparam logic [1:0] MODE_SIGNED = 2'd3;

    // Button codes
    localparam logic [2:0] BTN_NONE   = 3'd0;
    localparam logic [2:0] BTN_SELECT = 3'd1;
    localparam logic [2:0] BTN_LEFT   = 3'd2;
    localparam logic [2:0] BTN_UP     = 3'd3;
    localparam logic [2:0] BTN_DOWN   = 3'd4;
    localparam logic [2:0] BTN_RIGHT  = 3'd5;

    // Event codes
    localparam logic [3:0] EV_NONE         = 4'd0;
    localparam logic [3:0] EV_LOGIN_START  = 4'd1;
    localparam logic [3:0] EV_WRONG        = 4'd2;
    localparam logic [3:0] EV_WRONG_ALARM  = 4'd3;
    localparam logic [3:0] EV_LOGIN        = 4'd4;
    localparam logic [3:0] EV_LOGIN_ALMOFF = 4'd5;
    localparam logic [3:0] EV_CANCEL       = 4'd6;
    localparam logic [3:0] EV_LOCK_TOGGLE  = 4'd7;
    localparam logic [3:0] EV_ALARM_TOGGLE = 4'd8;
    localparam logic [3:0] EV_LOGOUT       = 4'd9;

    // Register indexes
    localparam logic [1:0] REG_USER_COUNT = 2'd0;
    localparam logic [1:0] REG_CODE_ONE   = 2'd1;
    localparam logic [1:0] REG_CODE_TWO   = 2'd2;
    localparam logic [1:0] REG_CODE_THREE = 2'd3;

    // Register reset values
    localparam logic [1:0]  RST_USER_COUNT = 2'd3;
    localparam logic [15:0] RST_CODE_ONE   = 16'h0000;
    localparam logic [15:0] RST_CODE_TWO   = 16'h2121;
    localparam logic [15:0] RST_CODE_THREE = 16'h6789;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [3:0] WRONG_MAX = 4'd15;
    localparam logic [3:0] WRONG_ALARM_AT = 4'd3;
    localparam logic [1:0] USER_FIRST = 2'd1;
    localparam logic [1:0] USER_TWO   = 2'd2;
    localparam logic [1:0] USER_THREE = 2'd3;

    function automatic logic [1:0] state_to_mode(input t_state st);
        logic [1:0] m;
        case (st)
            ST_IDLE:   m = MODE_IDLE;
            ST_PICK:   m = MODE_PICK;
            ST_ENTRY:  m = MODE_ENTRY;
            ST_SIGNED: m = MODE_SIGNED;
            default:   m = MODE_IDLE;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/multi_user_code_lock_controller.sv =====
// Channel   Handshake               Payload
// request   i_in_valid/o_in_ready   i_button
// result    o_out_valid/i_out_ready o_mode .. o_event_res
// config    psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// One request per cycle sustained while the result is taken; a stalled result holds
// the flow. An accepted request waits in the input register, then the state update
// loads the result register.
// Synchronous active-low reset returns the controller to idle and the registers to
// their defaults; no clearing pass is needed.
// A stalled result holds the step logic; the input register still takes one request.
`default_nettype none

`include "assert_macros.svh"

module multi_user_code_lock_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_button,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_mode,
    output logic [1:0]       o_selected_user,
    output logic [15:0]      o_entered_digits,
    output logic [1:0]       o_cursor_position,
    output logic [3:0]       o_wrong_count,
    output logic             o_lock_on,
    output logic             o_alarm_on,
    output logic [3:0]       o_event_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic [1:0]  r_user_count;
    logic [15:0] r_code_one;
    logic [15:0] r_code_two;
    logic [15:0] r_code_three;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_count <= mucl_pkg::RST_USER_COUNT;
            r_code_one   <= mucl_pkg::RST_CODE_ONE;
            r_code_two   <= mucl_pkg::RST_CODE_TWO;
            r_code_three <= mucl_pkg::RST_CODE_THREE;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                mucl_pkg::REG_USER_COUNT: r_user_count <= pwdata[1:0];
                mucl_pkg::REG_CODE_ONE:   r_code_one   <= pwdata[15:0];
                mucl_pkg::REG_CODE_TWO:   r_code_two   <= pwdata[15:0];
                mucl_pkg::REG_CODE_THREE: r_code_three <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mucl_pkg::REG_USER_COUNT: prdata = {30'd0, r_user_count};
            mucl_pkg::REG_CODE_ONE:   prdata = {16'd0, r_code_one};
            mucl_pkg::REG_CODE_TWO:   prdata = {16'd0, r_code_two};
            mucl_pkg::REG_CODE_THREE: prdata = {16'd0, r_code_three};
            default:                  prdata = 32'd0;
        endcase
    end

    // input register
    logic       r_in_vld;
    logic [2:0] r_button;
    logic       r_out_vld;
    logic       w_adv;

    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_button <= i_button;
        end
    end

    // controller state
    mucl_pkg::t_state r_state, n_state;
    logic [1:0] r_user, n_user;
    logic [3:0] r_digit [4];
    logic [3:0] n_digit [4];
    logic [1:0] r_cursor, n_cursor;
    logic [3:0] r_wrong, n_wrong;
    logic       r_lock, n_lock;
    logic       r_alarm, n_alarm;
    logic [3:0] n_event;

    logic [15:0] w_code;
    logic [15:0] w_entered;
    logic [3:0]  w_cur_digit;
    logic [3:0]  w_wrong_inc;

    always_comb begin
        case (r_user)
            mucl_pkg::USER_TWO:   w_code = r_code_two;
            mucl_pkg::USER_THREE: w_code = r_code_three;
            default:              w_code = r_code_one;
        endcase
    end

    assign w_entered   = {r_digit[3], r_digit[2], r_digit[1], r_digit[0]};
    assign w_cur_digit = r_digit[r_cursor];
    assign w_wrong_inc = (r_wrong < mucl_pkg::WRONG_MAX) ? r_wrong + 4'd1 : r_wrong;

    always_comb begin
        n_state = r_state;
        n_user  = r_user;
        n_digit = r_digit;
        n_cursor = r_cursor;
        n_wrong = r_wrong;
        n_lock  = r_lock;
        n_alarm = r_alarm;
        n_event = mucl_pkg::EV_NONE;
        case (r_state)
            mucl_pkg::ST_IDLE: begin
                if (r_button != mucl_pkg::BTN_NONE) begin
                    n_state = mucl_pkg::ST_PICK;
                end
            end
            mucl_pkg::ST_PICK: begin
                if (r_button == mucl_pkg::BTN_RIGHT && r_user < r_user_count) begin
                    n_user = r_user + 2'd1;
                end else if (r_button == mucl_pkg::BTN_LEFT && r_user > mucl_pkg::USER_FIRST) begin
                    n_user = r_user - 2'd1;
                end else if (r_button == mucl_pkg::BTN_SELECT) begin
                    n_state = mucl_pkg::ST_IDLE;
                end else if (r_button == mucl_pkg::BTN_DOWN) begin
                    n_state = mucl_pkg::ST_ENTRY;
                    n_event = mucl_pkg::EV_LOGIN_START;
                end
            end
            mucl_pkg::ST_ENTRY: begin
                if (r_button == mucl_pkg::BTN_LEFT) begin
                    if (w_entered != w_code) begin
                        n_wrong = w_wrong_inc;
                        if (w_wrong_inc == mucl_pkg::WRONG_ALARM_AT) begin
                            n_alarm = 1'b1;
                            n_event = mucl_pkg::EV_WRONG_ALARM;
                        end else begin
                            n_event = mucl_pkg::EV_WRONG;
                        end
                    end else begin
                        n_event  = r_alarm ? mucl_pkg::EV_LOGIN_ALMOFF : mucl_pkg::EV_LOGIN;
                        n_alarm  = 1'b0;
                        n_state  = mucl_pkg::ST_SIGNED;
                        n_wrong  = 4'd0;
                        n_digit  = '{default: 4'd0};
                        n_cursor = 2'd0;
                    end
                end else if (r_button == mucl_pkg::BTN_UP && w_cur_digit < mucl_pkg::DIGIT_MAX) begin
                    n_digit[r_cursor] = w_cur_digit + 4'd1;
                end else if (r_button == mucl_pkg::BTN_DOWN && w_cur_digit != 4'd0) begin
                    n_digit[r_cursor] = w_cur_digit - 4'd1;
                end else if (r_button == mucl_pkg::BTN_RIGHT) begin
                    n_cursor = r_cursor + 2'd1;
                end else if (r_button == mucl_pkg::BTN_SELECT) begin
                    n_state = mucl_pkg::ST_IDLE;
                    n_event = mucl_pkg::EV_CANCEL;
                end
            end
            mucl_pkg::ST_SIGNED: begin
                if (r_button == mucl_pkg::BTN_UP) begin
                    n_lock  = !r_lock;
                    n_event = mucl_pkg::EV_LOCK_TOGGLE;
                end else if (r_button == mucl_pkg::BTN_DOWN) begin
                    n_alarm = !r_alarm;
                    n_event = mucl_pkg::EV_ALARM_TOGGLE;
                end else if (r_button == mucl_pkg::BTN_SELECT) begin
                    n_state = mucl_pkg::ST_IDLE;
                    n_event = mucl_pkg::EV_LOGOUT;
                end
            end
            default: begin
                n_state = mucl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mucl_pkg::ST_IDLE;
            r_user   <= mucl_pkg::USER_FIRST;
            r_digit  <= '{default: 4'd0};
            r_cursor <= 2'd0;
            r_wrong  <= 4'd0;
            r_lock   <= 1'b0;
            r_alarm  <= 1'b0;
        end else if (w_adv) begin
            r_state  <= n_state;
            r_user   <= n_user;
            r_digit  <= n_digit;
            r_cursor <= n_cursor;
            r_wrong  <= n_wrong;
            r_lock   <= n_lock;
            r_alarm  <= n_alarm;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_mode            <= mucl_pkg::state_to_mode(n_state);
            o_selected_user   <= n_user;
            o_entered_digits  <= {n_digit[3], n_digit[2], n_digit[1], n_digit[0]};
            o_cursor_position <= n_cursor;
            o_wrong_count     <= n_wrong;
            o_lock_on         <= n_lock;
            o_alarm_on        <= n_alarm;
            o_event_res       <= n_event;
        end
    end

    assign o_out_valid = r_out_vld;

    logic w_alarm_rise;
    logic w_alarm_why;
    logic w_login_out;
    logic w_entry_clear;
    logic w_out_stall;

    assign w_alarm_rise  = w_adv && !r_alarm && n_alarm;
    assign w_alarm_why   = (n_event == mucl_pkg::EV_WRONG_ALARM)
                        || (n_event == mucl_pkg::EV_ALARM_TOGGLE);
    assign w_login_out   = o_out_valid && ((o_event_res == mucl_pkg::EV_LOGIN)
                        || (o_event_res == mucl_pkg::EV_LOGIN_ALMOFF));
    assign w_entry_clear = (o_entered_digits == 16'd0) && (o_cursor_position == 2'd0)
                        && (o_wrong_count == 4'd0) && !o_alarm_on;
    assign w_out_stall   = r_in_vld && r_out_vld && !i_out_ready;

    `ASSERT_CLK(a_alarm_cause, i_clk, i_rst_n, w_alarm_rise |-> w_alarm_why, "alarm without cause")
    `ASSERT_CLK(a_login_clears, i_clk, i_rst_n, w_login_out |-> w_entry_clear, "login kept entry")
    `ASSERT_CLK(a_ready_stall, i_clk, i_rst_n, !o_in_ready |-> w_out_stall, "ready drop, no stall")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 228;
    localparam int STALL_LIMIT  = 5000;

    // Spare button codes; they only wake the controller from idle
    localparam logic [2:0] BTN_SPARE_SIX   = 3'd6;
    localparam logic [2:0] BTN_SPARE_SEVEN = 3'd7;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  user;
        logic [15:0] digits;
        logic [1:0]  cursor;
        logic [3:0]  wrongs;
        logic        lock;
        logic        alarm;
        logic [3:0]  ev;
    } t_lock_status;

    class t_lock_predictor;
        logic [1:0]   user_limit;
        logic [15:0]  codes [1:3];
        logic [1:0]   mode;
        logic [1:0]   user;
        logic [3:0]   digits [4];
        logic [1:0]   cursor;
        logic [3:0]   wrongs;
        logic         lock;
        logic         alarm;
        t_lock_status expected_status_q[$];
        int           errors;
        int           checked;
        int           requests;
        int           event_hits [16];
        int           peak_wrongs;

        function new();
            user_limit                    = mucl_pkg::RST_USER_COUNT;
            codes[mucl_pkg::USER_FIRST]   = mucl_pkg::RST_CODE_ONE;
            codes[mucl_pkg::USER_TWO]     = mucl_pkg::RST_CODE_TWO;
            codes[mucl_pkg::USER_THREE]   = mucl_pkg::RST_CODE_THREE;
            mode                          = mucl_pkg::MODE_IDLE;
            user                          = mucl_pkg::USER_FIRST;
            for (int i = 0; i < 4; i++) digits[i] = '0;
            cursor              = '0;
            wrongs              = '0;
            lock                = 1'b0;
            alarm               = 1'b0;
            errors              = 0;
            checked             = 0;
            requests            = 0;
            peak_wrongs         = 0;
            for (int i = 0; i < 16; i++) event_hits[i] = 0;
        endfunction

        function logic [15:0] digit_word();
            return {digits[3], digits[2], digits[1], digits[0]};
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                mucl_pkg::REG_USER_COUNT: user_limit = data[1:0];
                mucl_pkg::REG_CODE_ONE:   codes[mucl_pkg::USER_FIRST] = data[15:0];
                mucl_pkg::REG_CODE_TWO:   codes[mucl_pkg::USER_TWO] = data[15:0];
                mucl_pkg::REG_CODE_THREE: codes[mucl_pkg::USER_THREE] = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] register_value(logic [1:0] idx);
            case (idx)
                mucl_pkg::REG_USER_COUNT: return {14'd0, user_limit};
                mucl_pkg::REG_CODE_ONE:   return codes[mucl_pkg::USER_FIRST];
                mucl_pkg::REG_CODE_TWO:   return codes[mucl_pkg::USER_TWO];
                default:                  return codes[mucl_pkg::USER_THREE];
            endcase
        endfunction

        function logic [3:0] confirm_code();
            logic [3:0] ev;
            if (digit_word() != codes[user]) begin
                if (wrongs < mucl_pkg::WRONG_MAX) wrongs++;
                if (wrongs == mucl_pkg::WRONG_ALARM_AT) begin
                    alarm = 1'b1;
                    return mucl_pkg::EV_WRONG_ALARM;
                end
                return mucl_pkg::EV_WRONG;
            end
            ev     = alarm ? mucl_pkg::EV_LOGIN_ALMOFF : mucl_pkg::EV_LOGIN;
            alarm  = 1'b0;
            mode   = mucl_pkg::MODE_SIGNED;
            wrongs = '0;
            for (int i = 0; i < 4; i++) digits[i] = '0;
            cursor = '0;
            return ev;
        endfunction

        function void note_button(logic [2:0] btn);
            logic [3:0]   ev;
            logic [1:0]   c;
            t_lock_status st;
            ev = mucl_pkg::EV_NONE;
            c  = cursor;
            case (mode)
                mucl_pkg::MODE_IDLE: begin
                    if (btn != mucl_pkg::BTN_NONE) mode = mucl_pkg::MODE_PICK;
                end
                mucl_pkg::MODE_PICK: begin
                    if (btn == mucl_pkg::BTN_RIGHT && user < user_limit) user++;
                    else if (btn == mucl_pkg::BTN_LEFT && user > mucl_pkg::USER_FIRST) user--;
                    else if (btn == mucl_pkg::BTN_SELECT) mode = mucl_pkg::MODE_IDLE;
                    else if (btn == mucl_pkg::BTN_DOWN) begin
                        mode = mucl_pkg::MODE_ENTRY;
                        ev   = mucl_pkg::EV_LOGIN_START;
                    end
                end
                mucl_pkg::MODE_ENTRY: begin
                    if (btn == mucl_pkg::BTN_LEFT) ev = confirm_code();
                    else if (btn == mucl_pkg::BTN_UP && digits[c] < mucl_pkg::DIGIT_MAX)
                        digits[c]++;
                    else if (btn == mucl_pkg::BTN_DOWN && digits[c] > 4'd0) digits[c]--;
                    else if (btn == mucl_pkg::BTN_RIGHT) cursor = c + 2'd1;
                    else if (btn == mucl_pkg::BTN_SELECT) begin
                        mode = mucl_pkg::MODE_IDLE;
                        ev   = mucl_pkg::EV_CANCEL;
                    end
                end
                default: begin
                    if (btn == mucl_pkg::BTN_UP) begin
                        lock = ~lock;
                        ev   = mucl_pkg::EV_LOCK_TOGGLE;
                    end else if (btn == mucl_pkg::BTN_DOWN) begin
                        alarm = ~alarm;
                        ev    = mucl_pkg::EV_ALARM_TOGGLE;
                    end else if (btn == mucl_pkg::BTN_SELECT) begin
                        mode = mucl_pkg::MODE_IDLE;
                        ev   = mucl_pkg::EV_LOGOUT;
                    end
                end
            endcase
            st.mode   = mode;
            st.user   = user;
            st.digits = digit_word();
            st.cursor = cursor;
            st.wrongs = wrongs;
            st.lock   = lock;
            st.alarm  = alarm;
            st.ev     = ev;
            expected_status_q.push_back(st);
            requests++;
            event_hits[ev]++;
            if (int'(wrongs) > peak_wrongs) peak_wrongs = int'(wrongs);
        endfunction

        function void compare_field(string label, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t  %s mismatch: expected %0d, got %0d", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_status(t_lock_status got);
            t_lock_status want;
            if (expected_status_q.size() == 0) begin
                $display("%0t  result with no request waiting: expected none, got mode %0d event %0d",
                         $time, got.mode, got.ev);
                errors++;
                return;
            end
            want = expected_status_q.pop_front();
            checked++;
            compare_field("mode", 16'(want.mode), 16'(got.mode));
            compare_field("selected_user", 16'(want.user), 16'(got.user));
            compare_field("entered_digits", want.digits, got.digits);
            compare_field("cursor_position", 16'(want.cursor), 16'(got.cursor));
            compare_field("wrong_count", 16'(want.wrongs), 16'(got.wrongs));
            compare_field("lock_on", 16'(want.lock), 16'(got.lock));
            compare_field("alarm_on", 16'(want.alarm), 16'(got.alarm));
            compare_field("event_res", 16'(want.ev), 16'(got.ev));
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_button;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_mode;
    logic [1:0]  o_selected_user;
    logic [15:0] o_entered_digits;
    logic [1:0]  o_cursor_position;
    logic [3:0]  o_wrong_count;
    logic        o_lock_on;
    logic        o_alarm_on;
    logic [3:0]  o_event_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_lock_predictor sb;
    int              send_idle_pct;
    int              stall_pct;
    int              quiet_cycles;

    multi_user_code_lock_controller u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_button          (i_button),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_mode            (o_mode),
        .o_selected_user   (o_selected_user),
        .o_entered_digits  (o_entered_digits),
        .o_cursor_position (o_cursor_position),
        .o_wrong_count     (o_wrong_count),
        .o_lock_on         (o_lock_on),
        .o_alarm_on        (o_alarm_on),
        .o_event_res       (o_event_res),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: check accepted results, then pick next cycle's ready
    always @(posedge i_clk) begin : result_side
        t_lock_status got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.mode   = o_mode;
                got.user   = o_selected_user;
                got.digits = o_entered_digits;
                got.cursor = o_cursor_position;
                got.wrongs = o_wrong_count;
                got.lock   = o_lock_on;
                got.alarm  = o_alarm_on;
                got.ev     = o_event_res;
                sb.check_status(got);
            end
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t  no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_button(input logic [2:0] btn);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_button   <= btn;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_button(btn);
    endtask

    // Hold off requests until every expected result is back
    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register, then read it back; leaves psel high for the next transfer
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        logic [15:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, data);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mask = (idx == mucl_pkg::REG_USER_COUNT) ? 16'h0003 : 16'hFFFF;
        if ((prdata[15:0] & mask) !== sb.register_value(idx)) begin
            $display("%0t  register %0d readback mismatch: expected %0d, got %0d",
                     $time, idx, sb.register_value(idx), prdata[15:0] & mask);
            sb.errors++;
        end
    endtask

    task automatic program_lock(input logic [1:0] limit, input logic [15:0] c1,
                                input logic [15:0] c2, input logic [15:0] c3);
        write_register(mucl_pkg::REG_USER_COUNT, {30'($urandom), limit});
        write_register(mucl_pkg::REG_CODE_ONE, {16'($urandom), c1});
        write_register(mucl_pkg::REG_CODE_TWO, {16'($urandom), c2});
        write_register(mucl_pkg::REG_CODE_THREE, {16'($urandom), c3});
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_code();
        logic [15:0] code;
        for (int i = 0; i < 4; i++) code[4*i +: 4] = 4'($urandom_range(0, 9));
        return code;
    endfunction

    function automatic logic [15:0] any_code();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : random_code();
    endfunction

    // Mostly walk the controller toward a login, with noise mixed in
    function automatic logic [2:0] next_button();
        int          r;
        logic [15:0] goal;
        logic [3:0]  want;
        logic [3:0]  have;
        logic [2:0]  btn;
        r   = $urandom_range(0, 99);
        btn = 3'($urandom_range(0, 7));
        case (sb.mode)
            mucl_pkg::MODE_IDLE: ;
            mucl_pkg::MODE_PICK: begin
                if (r < 40) btn = mucl_pkg::BTN_DOWN;
                else if (r < 65) btn = mucl_pkg::BTN_RIGHT;
                else if (r < 85) btn = mucl_pkg::BTN_LEFT;
                else if (r < 90) btn = mucl_pkg::BTN_SELECT;
            end
            mucl_pkg::MODE_ENTRY: begin
                goal = sb.codes[sb.user];
                want = goal[4*sb.cursor +: 4];
                have = sb.digits[sb.cursor];
                if (r >= 20) begin
                    if (sb.digit_word() == goal || r < 23) btn = mucl_pkg::BTN_LEFT;
                    else if (have < want) btn = mucl_pkg::BTN_UP;
                    else if (have > want) btn = mucl_pkg::BTN_DOWN;
                    else btn = mucl_pkg::BTN_RIGHT;
                end
            end
            default: begin
                if (r < 35) btn = mucl_pkg::BTN_UP;
                else if (r < 70) btn = mucl_pkg::BTN_DOWN;
                else if (r < 85) btn = mucl_pkg::BTN_SELECT;
            end
        endcase
        return btn;
    endfunction

    // Wake-ups with codes 6 and 7, user limits, digit floor, ignored codes,
    // wrong codes past the alarm, cancel, cursor wrap, login with alarm, signed-in actions
    logic [2:0] directed_buttons [30] = '{
        mucl_pkg::BTN_NONE, BTN_SPARE_SIX, mucl_pkg::BTN_SELECT, BTN_SPARE_SEVEN,
        mucl_pkg::BTN_RIGHT, mucl_pkg::BTN_RIGHT, mucl_pkg::BTN_RIGHT,
        mucl_pkg::BTN_LEFT, mucl_pkg::BTN_LEFT, mucl_pkg::BTN_LEFT,
        mucl_pkg::BTN_DOWN, mucl_pkg::BTN_DOWN, BTN_SPARE_SIX, mucl_pkg::BTN_UP,
        mucl_pkg::BTN_LEFT, mucl_pkg::BTN_LEFT, mucl_pkg::BTN_LEFT, mucl_pkg::BTN_LEFT,
        mucl_pkg::BTN_SELECT,
        mucl_pkg::BTN_UP, mucl_pkg::BTN_DOWN, mucl_pkg::BTN_DOWN,
        mucl_pkg::BTN_RIGHT, mucl_pkg::BTN_RIGHT, mucl_pkg::BTN_RIGHT, mucl_pkg::BTN_RIGHT,
        mucl_pkg::BTN_LEFT,
        mucl_pkg::BTN_UP, mucl_pkg::BTN_DOWN, mucl_pkg::BTN_SELECT
    };

    initial begin
        sb            = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_button      <= mucl_pkg::BTN_NONE;
        i_out_ready   <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_buttons[i]) send_button(directed_buttons[i]);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_requests();
            case (phase)
                0: program_lock(2'd3, random_code(), random_code(), random_code());
                1: program_lock(2'd1, 16'hFFFF, random_code(), 16'hFFFF);
                2: program_lock(2'd0, 16'h0000, 16'h9999, random_code());
                3: program_lock(2'd2, 16'h9999, random_code(), 16'hFFFF);
                default: program_lock(2'($urandom_range(0, 3)), any_code(), any_code(),
                                      any_code());
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            repeat (PHASE_ITEMS) send_button(next_button());
        end

        drain_requests();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d button requests over %0d traffic phases, %0d results checked.",
                 sb.requests, PHASES, sb.checked);
        $display("Logins %0d, wrong codes %0d, alarm trips %0d, cancels %0d, peak wrong count %0d.",
                 sb.event_hits[mucl_pkg::EV_LOGIN] + sb.event_hits[mucl_pkg::EV_LOGIN_ALMOFF],
                 sb.event_hits[mucl_pkg::EV_WRONG] + sb.event_hits[mucl_pkg::EV_WRONG_ALARM],
                 sb.event_hits[mucl_pkg::EV_WRONG_ALARM], sb.event_hits[mucl_pkg::EV_CANCEL],
                 sb.peak_wrongs);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/mucl_pkg.sv
src/multi_user_code_lock_controller.sv
sim/tb.sv
